// File: src/oss_pkg.sv
package oss_pkg;

    localparam int SampleW = 24;
    localparam int IntW    = 48;
    localparam int Frac    = SampleW - 1;
    localparam int CoefW   = 32;
    localparam int HalfW   = IntW / 2;
    localparam int ProdW   = 2 * IntW;
    localparam int CfgIdxW = 3;

    localparam logic signed [IntW-1:0] IMax = {1'b0, {(IntW-1){1'b1}}};
    localparam logic signed [IntW-1:0] IMin = {1'b1, {(IntW-1){1'b0}}};
    localparam logic signed [IntW-1:0] One  = IntW'(64'd1 << Frac);
    localparam logic signed [IntW-1:0] SoftCoef = IntW'(64'd189837554);

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_IN_GAIN   = 3'd0,
        CFG_OUT_GAIN  = 3'd1,
        CFG_HP_AMOUNT = 3'd2,
        CFG_LP_B0     = 3'd3,
        CFG_LP_A1     = 3'd4,
        CFG_LP_A2     = 3'd5
    } t_cfg_idx;

    // Right shift applied to a product before rounding.
    typedef enum logic [2:0] {
        SH18 = 3'd0,
        SH23 = 3'd1,
        SH29 = 3'd2,
        SH30 = 3'd3,
        SH32 = 3'd4
    } t_shift;

    // One step is one multiply on the shared unit plus its writeback.
    typedef enum logic [4:0] {
        ST_GAIN  = 5'd0,
        ST_HP    = 5'd1,
        ST_B1_B0 = 5'd2,
        ST_B1_X1 = 5'd3,
        ST_B1_X2 = 5'd4,
        ST_B1_Y1 = 5'd5,
        ST_B1_Y2 = 5'd6,
        ST_SQ    = 5'd7,
        ST_P4    = 5'd8,
        ST_P5    = 5'd9,
        ST_SOFT  = 5'd10,
        ST_B2_B0 = 5'd11,
        ST_B2_X1 = 5'd12,
        ST_B2_X2 = 5'd13,
        ST_B2_Y1 = 5'd14,
        ST_B2_Y2 = 5'd15,
        ST_OUTG  = 5'd16
    } t_step;

    typedef struct packed {
        logic  load_in;
        logic  start;
        logic  wb;
        logic  out_load;
        t_step step;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic out_free;
    } t_sts;

    function automatic logic signed [IntW-1:0] sat_add(
        input logic signed [IntW-1:0] a, input logic signed [IntW-1:0] b);
        logic signed [IntW:0] s;
        s = {a[IntW-1], a} + {b[IntW-1], b};
        if (s[IntW] != s[IntW-1]) begin
            return s[IntW] ? IMin : IMax;
        end
        return s[IntW-1:0];
    endfunction

    function automatic logic signed [IntW-1:0] sat_sub(
        input logic signed [IntW-1:0] a, input logic signed [IntW-1:0] b);
        logic signed [IntW:0] s;
        s = {a[IntW-1], a} - {b[IntW-1], b};
        if (s[IntW] != s[IntW-1]) begin
            return s[IntW] ? IMin : IMax;
        end
        return s[IntW-1:0];
    endfunction

    // Hard clip to plus or minus one.
    function automatic logic signed [IntW-1:0] clip_one(input logic signed [IntW-1:0] a);
        if (a > One) begin
            return One;
        end
        if (a < -One) begin
            return -One;
        end
        return a;
    endfunction

    function automatic logic [SampleW-1:0] sat_sample(input logic signed [IntW-1:0] a);
        if (a > One - 1) begin
            return {1'b0, {(SampleW-1){1'b1}}};
        end
        if (a < -One) begin
            return {1'b1, {(SampleW-1){1'b0}}};
        end
        return a[SampleW-1:0];
    endfunction

endpackage

// File: src/oss_mul.sv
module oss_mul (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [oss_pkg::IntW-1:0]     i_a,
    input  logic signed [oss_pkg::IntW-1:0]     i_b,
    input  oss_pkg::t_shift                     i_shift,
    output logic                                o_done,
    output logic signed [oss_pkg::IntW-1:0]     o_result
);

    logic                            r_busy;
    logic                            r_fin;
    logic                            r_done;
    logic [1:0]                      r_cnt;
    logic                            r_neg;
    logic [oss_pkg::IntW-1:0]        r_ua;
    logic [oss_pkg::IntW-1:0]        r_ub;
    logic [oss_pkg::ProdW-1:0]       r_acc;
    oss_pkg::t_shift                 r_shift;
    logic signed [oss_pkg::IntW-1:0] r_res;

    logic [oss_pkg::HalfW-1:0]   a_part;
    logic [oss_pkg::HalfW-1:0]   b_part;
    logic [oss_pkg::IntW-1:0]    pp;
    logic [oss_pkg::ProdW-1:0]   pp_ext;
    logic [oss_pkg::ProdW-1:0]   pp_sh;
    logic [5:0]                  sh_amt;
    logic [oss_pkg::ProdW:0]     rnd;
    logic [oss_pkg::ProdW:0]     mag_w;
    logic [oss_pkg::ProdW:0]     limit;
    logic [oss_pkg::IntW-1:0]    mag;
    logic [oss_pkg::IntW-1:0]    a_mag;
    logic [oss_pkg::IntW-1:0]    b_mag;

    // Operand magnitudes; the sign is carried separately.
    assign a_mag = i_a[oss_pkg::IntW-1] ? oss_pkg::IntW'(-i_a) : i_a;
    assign b_mag = i_b[oss_pkg::IntW-1] ? oss_pkg::IntW'(-i_b) : i_b;

    // One half-by-half partial product per cycle.
    assign a_part = r_cnt[1] ? r_ua[oss_pkg::IntW-1:oss_pkg::HalfW] : r_ua[oss_pkg::HalfW-1:0];
    assign b_part = r_cnt[0] ? r_ub[oss_pkg::IntW-1:oss_pkg::HalfW] : r_ub[oss_pkg::HalfW-1:0];
    assign pp     = a_part * b_part;
    assign pp_ext = {{oss_pkg::IntW{1'b0}}, pp};

    always_comb begin
        case (r_cnt)
            2'b00:   pp_sh = pp_ext;
            2'b11:   pp_sh = pp_ext << oss_pkg::IntW;
            default: pp_sh = pp_ext << oss_pkg::HalfW;
        endcase
    end

    always_comb begin
        case (r_shift)
            oss_pkg::SH18: sh_amt = 6'd18;
            oss_pkg::SH23: sh_amt = 6'd23;
            oss_pkg::SH29: sh_amt = 6'd29;
            oss_pkg::SH30: sh_amt = 6'd30;
            oss_pkg::SH32: sh_amt = 6'd32;
            default:       sh_amt = 6'd30;
        endcase
    end

    // Round half away from zero on the magnitude, then saturate.
    assign rnd   = {1'b0, r_acc} + ((oss_pkg::ProdW+1)'(1) << (sh_amt - 6'd1));
    assign mag_w = rnd >> sh_amt;
    assign limit = {{(oss_pkg::ProdW-oss_pkg::IntW+1){1'b0}}, r_neg,
                    {(oss_pkg::IntW-1){~r_neg}}};
    assign mag   = (mag_w > limit) ? limit[oss_pkg::IntW-1:0] : mag_w[oss_pkg::IntW-1:0];

    // Sequencing of the four partial products and the finishing cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Operand, accumulator and result registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ua    <= a_mag;
            r_ub    <= b_mag;
            r_neg   <= i_a[oss_pkg::IntW-1] ^ i_b[oss_pkg::IntW-1];
            r_shift <= i_shift;
            r_acc   <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + pp_sh;
        end else if (r_fin) begin
            r_res <= r_neg ? oss_pkg::IntW'(-mag) : mag;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy && !r_fin)
        else $error("multiplier restarted while busy");
    a_done_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> r_done)
        else $error("multiplier finish did not signal done");
`endif

endmodule

// File: src/oss_ctrl.sv
module oss_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  oss_pkg::t_sts i_sts,
    output oss_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state         r_state;
    t_state         n_state;
    oss_pkg::t_step r_step;
    oss_pkg::t_step n_step;
    logic           accept;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Step through the multiply schedule one step at a time.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_ISSUE;
                    n_step  = oss_pkg::ST_GAIN;
                end
            end
            S_ISSUE: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (i_sts.mul_done) begin
                    if (r_step == oss_pkg::ST_OUTG) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_ISSUE;
                        n_step  = oss_pkg::t_step'(r_step + 5'd1);
                    end
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= oss_pkg::ST_GAIN;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.load_in  = accept;
        o_cmd.start    = (r_state == S_ISSUE);
        o_cmd.wb       = (r_state == S_WAIT) && i_sts.mul_done;
        o_cmd.out_load = (r_state == S_OUT) && i_sts.out_free;
        o_cmd.step     = r_step;
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_ISSUE) && (r_step == oss_pkg::ST_GAIN))
        else $error("accepted request did not start the schedule");
    a_out_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after output");
`endif

endmodule

// File: src/oss_dp.sv
module oss_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [oss_pkg::CfgIdxW-1:0]           i_cfg_index,
    input  logic [oss_pkg::CoefW-1:0]             i_cfg_data,
    input  logic signed [oss_pkg::SampleW-1:0]    i_sample_in,
    input  logic                                  i_out_stall,
    output logic                                  o_out_valid,
    output logic signed [oss_pkg::SampleW-1:0]    o_sample_out,
    input  oss_pkg::t_cmd                         i_cmd,
    output oss_pkg::t_sts                         o_sts
);

    localparam int W = oss_pkg::IntW;

    // Configuration registers.
    logic [31:0]        r_in_gain;
    logic [30:0]        r_out_gain;
    logic [31:0]        r_hp_amount;
    logic signed [31:0] r_lp_b0;
    logic signed [31:0] r_lp_a1;
    logic signed [31:0] r_lp_a2;

    // Filter state.
    logic signed [W-1:0] r_hp;
    logic signed [W-1:0] r_f_x1, r_f_x2, r_f_y1, r_f_y2;
    logic signed [W-1:0] r_s_x1, r_s_x2, r_s_y1, r_s_y2;

    // Working registers.
    logic signed [W-1:0]               r_x;
    logic signed [W-1:0]               r_y;
    logic signed [W-1:0]               r_p;
    logic [oss_pkg::SampleW-1:0]       r_res;
    logic [oss_pkg::SampleW-1:0]       r_out_data;
    logic                              r_out_valid;

    logic signed [W-1:0] op_a;
    logic signed [W-1:0] op_b;
    oss_pkg::t_shift     op_sh;
    logic signed [W-1:0] x_hp;
    logic signed [W-1:0] x_clip;
    logic signed [W-1:0] b0_w;
    logic signed [W-1:0] a1_w;
    logic signed [W-1:0] a2_w;
    logic signed [W-1:0] t;
    logic signed [W-1:0] y_sub;
    logic                mul_done;

    assign x_hp   = oss_pkg::sat_sub(r_x, r_hp);
    assign x_clip = oss_pkg::clip_one(r_x);
    assign b0_w   = W'(r_lp_b0);
    assign a1_w   = W'(r_lp_a1);
    assign a2_w   = W'(r_lp_a2);
    assign y_sub  = oss_pkg::sat_sub(r_y, t);

    // Operand selection for the shared multiplier.
    always_comb begin
        op_a  = '0;
        op_b  = '0;
        op_sh = oss_pkg::SH30;
        case (i_cmd.step)
            oss_pkg::ST_GAIN: begin
                op_a  = r_x;
                op_b  = W'({1'b0, r_in_gain});
                op_sh = oss_pkg::SH18;
            end
            oss_pkg::ST_HP: begin
                op_a  = x_hp;
                op_b  = W'({1'b0, r_hp_amount});
                op_sh = oss_pkg::SH32;
            end
            oss_pkg::ST_B1_B0: begin
                op_a = x_hp;
                op_b = b0_w;
            end
            oss_pkg::ST_B1_X1: begin
                op_a  = r_f_x1;
                op_b  = b0_w;
                op_sh = oss_pkg::SH29;
            end
            oss_pkg::ST_B1_X2: begin
                op_a = r_f_x2;
                op_b = b0_w;
            end
            oss_pkg::ST_B1_Y1: begin
                op_a = r_f_y1;
                op_b = a1_w;
            end
            oss_pkg::ST_B1_Y2: begin
                op_a = r_f_y2;
                op_b = a2_w;
            end
            oss_pkg::ST_SQ: begin
                op_a  = x_clip;
                op_b  = x_clip;
                op_sh = oss_pkg::SH23;
            end
            oss_pkg::ST_P4: begin
                op_a  = r_p;
                op_b  = r_p;
                op_sh = oss_pkg::SH23;
            end
            oss_pkg::ST_P5: begin
                op_a  = r_p;
                op_b  = r_x;
                op_sh = oss_pkg::SH23;
            end
            oss_pkg::ST_SOFT: begin
                op_a = r_p;
                op_b = oss_pkg::SoftCoef;
            end
            oss_pkg::ST_B2_B0: begin
                op_a = r_x;
                op_b = b0_w;
            end
            oss_pkg::ST_B2_X1: begin
                op_a  = r_s_x1;
                op_b  = b0_w;
                op_sh = oss_pkg::SH29;
            end
            oss_pkg::ST_B2_X2: begin
                op_a = r_s_x2;
                op_b = b0_w;
            end
            oss_pkg::ST_B2_Y1: begin
                op_a = r_s_y1;
                op_b = a1_w;
            end
            oss_pkg::ST_B2_Y2: begin
                op_a = r_s_y2;
                op_b = a2_w;
            end
            oss_pkg::ST_OUTG: begin
                op_a = r_y;
                op_b = W'({1'b0, r_out_gain});
            end
            default: begin
                op_a = '0;
            end
        endcase
    end

    oss_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start),
        .i_a      (op_a),
        .i_b      (op_b),
        .i_shift  (op_sh),
        .o_done   (mul_done),
        .o_result (t)
    );

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_gain   <= 32'd262144;
            r_out_gain  <= 31'd1073741824;
            r_hp_amount <= 32'd2963527;
            r_lp_b0     <= 32'sd599052000;
            r_lp_a1     <= 32'sd894000000;
            r_lp_a2     <= 32'sd428322000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                oss_pkg::CFG_IN_GAIN:   r_in_gain   <= i_cfg_data;
                oss_pkg::CFG_OUT_GAIN:  r_out_gain  <= i_cfg_data[30:0];
                oss_pkg::CFG_HP_AMOUNT: r_hp_amount <= i_cfg_data;
                oss_pkg::CFG_LP_B0:     r_lp_b0     <= i_cfg_data;
                oss_pkg::CFG_LP_A1:     r_lp_a1     <= i_cfg_data;
                oss_pkg::CFG_LP_A2:     r_lp_a2     <= i_cfg_data;
                default:                r_in_gain   <= r_in_gain;
            endcase
        end
    end

    // Filter state updates at the end of each biquad and the highpass step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hp   <= '0;
            r_f_x1 <= '0;
            r_f_x2 <= '0;
            r_f_y1 <= '0;
            r_f_y2 <= '0;
            r_s_x1 <= '0;
            r_s_x2 <= '0;
            r_s_y1 <= '0;
            r_s_y2 <= '0;
        end else if (i_cmd.wb) begin
            case (i_cmd.step)
                oss_pkg::ST_HP: begin
                    r_hp <= oss_pkg::sat_add(r_hp, t);
                end
                oss_pkg::ST_B1_Y2: begin
                    r_f_x2 <= r_f_x1;
                    r_f_x1 <= r_x;
                    r_f_y2 <= r_f_y1;
                    r_f_y1 <= y_sub;
                end
                oss_pkg::ST_B2_Y2: begin
                    r_s_x2 <= r_s_x1;
                    r_s_x1 <= r_x;
                    r_s_y2 <= r_s_y1;
                    r_s_y1 <= y_sub;
                end
                default: begin
                    r_hp <= r_hp;
                end
            endcase
        end
    end

    // Working registers of the signal chain.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_x <= W'(i_sample_in);
        end else if (i_cmd.start) begin
            if (i_cmd.step == oss_pkg::ST_B1_B0) begin
                r_x <= x_hp;
            end else if (i_cmd.step == oss_pkg::ST_SQ) begin
                r_x <= x_clip;
            end
        end else if (i_cmd.wb) begin
            case (i_cmd.step)
                oss_pkg::ST_GAIN: r_x <= t;
                oss_pkg::ST_B1_B0, oss_pkg::ST_B2_B0: r_y <= t;
                oss_pkg::ST_B1_X1, oss_pkg::ST_B1_X2,
                oss_pkg::ST_B2_X1, oss_pkg::ST_B2_X2: r_y <= oss_pkg::sat_add(r_y, t);
                oss_pkg::ST_B1_Y1, oss_pkg::ST_B2_Y1: r_y <= y_sub;
                oss_pkg::ST_B1_Y2: begin
                    r_y <= y_sub;
                    r_x <= y_sub;
                end
                oss_pkg::ST_B2_Y2: r_y <= y_sub;
                oss_pkg::ST_SQ, oss_pkg::ST_P4, oss_pkg::ST_P5: r_p <= t;
                oss_pkg::ST_SOFT: r_x <= oss_pkg::sat_sub(r_x, t);
                oss_pkg::ST_OUTG: r_res <= oss_pkg::sat_sample(t);
                default: r_p <= r_p;
            endcase
        end
    end

    // Output register: a finished result waits here while the next request runs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= r_res;
        end
    end

    assign o_sts.mul_done = mul_done;
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid    = r_out_valid;
    assign o_sample_out   = r_out_data;

endmodule

// File: src/output_stage_saturator_core.sv
// Output stage saturator: input gain, leaky highpass, biquad lowpass, hard clip,
// quintic soft clip, second biquad and output gain on one audio sample per request.
// Input channel: i_in_valid with i_sample_in; a request is taken on a rising edge
// where i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid with o_sample_out; the result is taken on a rising
// edge where o_out_valid is high and i_out_stall is low. One result per request.
// The schedule runs 17 multiplies on one shared unit, each made of issue, four 24x24
// partial products, round and saturate, and writeback; that unit sets the request rate,
// and a new request is taken only once the last result is in the output register.
// o_in_stall is high while a request is in flight.
// The output register holds a finished result while the next request is processed;
// if the receiver stalls with that register full, the block holds its new result
// and keeps o_in_stall high until the register frees.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data on the edge;
// write only while idle. Indexes past the last register are ignored.
// Reset (synchronous, active low) clears all filter state, empties the output
// register and restores the default coefficients and gains.
module output_stage_saturator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [oss_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [oss_pkg::CoefW-1:0]           i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [oss_pkg::SampleW-1:0]  i_sample_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [oss_pkg::SampleW-1:0]  o_sample_out
);

    oss_pkg::t_cmd cmd;
    oss_pkg::t_sts sts;

    oss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    oss_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample_in  (i_sample_in),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out),
        .i_cmd        (cmd),
        .o_sts        (sts)
    );

endmodule
